// ----- hw/rtl/crrpt_pkg.sv -----
package crrpt_pkg;

    localparam int unsigned ROUTE_ENTRIES_DEF   = 64;
    localparam int unsigned PENDING_ENTRIES_DEF = 64;

    localparam logic [1:0] OP_UPDATE   = 2'd0;
    localparam logic [1:0] OP_RESPONSE = 2'd1;
    localparam logic [1:0] OP_REQUEST  = 2'd2;
    localparam logic [1:0] OP_TICK     = 2'd3;

    localparam logic [1:0] ST_FORWARDED = 2'd0;
    localparam logic [1:0] ST_NO_MATCH  = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_TICK      = 2'd3;

    localparam logic [7:0] ROUTE_LIFE_RST = 8'd25;
    localparam logic [7:0] PEND_LIFE_RST  = 8'd120;

    localparam logic [0:0] REG_ROUTE_LIFE = 1'b0;
    localparam logic [0:0] REG_PEND_LIFE  = 1'b1;

    // one entry compare request to the shared matcher
    typedef struct packed {
        logic        valid;
        logic [31:0] entry_content;
        logic [31:0] entry_host;
        logic [31:0] key_content;
        logic [31:0] key_host;
        logic        use_host;
    } t_cmp_req;

    typedef struct packed {
        logic hit;
        logic free;
    } t_cmp_rsp;

endpackage

// ----- hw/rtl/content_router_route_pending_tables.sv -----
// Content router forwarding core. Each transaction on the slave stream is an
// update, request, response or tick and produces one result transaction.
// All work goes through one shared key comparator that visits one table entry
// per cycle, with table reads registered. A response scans the pending table;
// an update scans the route table and writes it back; a request scans the
// pending table, records the entry, then scans the route table; a tick walks
// the route table and then the pending table. The result then waits for
// m_axis_tready, and the next transaction is taken in the cycle after the
// result leaves. Tables default to 64 entries. Valid bits clear at reset;
// no clearing pass.
module content_router_route_pending_tables
    import crrpt_pkg::*;
#(
    parameter int unsigned ROUTE_ENTRIES   = ROUTE_ENTRIES_DEF,
    parameter int unsigned PENDING_ENTRIES = PENDING_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0], arrival_port[3:2], content_id[35:4], host_id[67:36], hop_count[75:68]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // forward_mask[3:0], out_hop_count[11:4], status[13:12]
    output logic [15:0] m_axis_tdata
);

    localparam int RW = $clog2(ROUTE_ENTRIES);
    localparam int PW = $clog2(PENDING_ENTRIES);
    localparam int CW = (RW > PW) ? RW + 1 : PW + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PSCAN  = 4'd1;
    localparam logic [3:0] S_PWRITE = 4'd2;
    localparam logic [3:0] S_RSCAN  = 4'd3;
    localparam logic [3:0] S_RWRITE = 4'd4;
    localparam logic [3:0] S_RTICK  = 4'd5;
    localparam logic [3:0] S_PTICK  = 4'd6;
    localparam logic [3:0] S_OUT    = 4'd7;

    logic [3:0] r_state;
    logic [7:0] r_route_life_cfg, r_pend_life_cfg;

    // latched item
    logic [1:0]  r_op, r_port;
    logic [31:0] r_cid, r_hid;
    logic [7:0]  r_hops;

    // tables
    logic [ROUTE_ENTRIES-1:0]   r_rvalid;
    logic [PENDING_ENTRIES-1:0] r_pvalid;
    logic [31:0] m_rcontent [ROUTE_ENTRIES];
    logic [17:0] m_rdata    [ROUTE_ENTRIES];   // port, hops, life
    logic [31:0] m_pcontent [PENDING_ENTRIES];
    logic [31:0] m_phost    [PENDING_ENTRIES];
    logic [9:0]  m_pdata    [PENDING_ENTRIES]; // port, life

    // scan control: issue index and index of data in the comparator output
    logic [CW-1:0] r_idx;      // address issued to memory
    logic          r_rd_v;     // memory read data valid (stage 1)
    logic [CW-1:0] r_rd_idx;
    logic          r_cmp_v;    // comparator output valid (stage 2)
    logic [CW-1:0] r_cmp_idx;
    logic [31:0]   r_rd_content, r_rd_host;
    logic [17:0]   r_rd_rdata;
    logic [9:0]    r_rd_pdata;
    logic [17:0]   r_cmp_rdata;
    logic [9:0]    r_cmp_pdata;
    logic          r_rd_valid_bit;

    logic          r_found, r_free_found;
    logic [CW-1:0] r_found_idx, r_free_idx;
    logic [17:0]   r_found_rdata;
    logic [9:0]    r_found_pdata;

    logic [3:0] r_mask;
    logic [7:0] r_ohops;
    logic [1:0] r_status;
    logic       r_pfull;

    t_cmp_req cmp_req;
    t_cmp_rsp cmp_rsp;

    logic scan_route;
    logic [CW-1:0] scan_len;
    logic scan_done;

    assign scan_route = (r_state == S_RSCAN) || (r_state == S_RTICK);
    assign scan_len = scan_route ? CW'(ROUTE_ENTRIES) : CW'(PENDING_ENTRIES);
    assign scan_done = (r_idx == scan_len) && !r_rd_v && !r_cmp_v;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {2'b00, r_status, r_ohops, r_mask};

    crrpt_match u_match (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (cmp_req),
        .o_rsp  (cmp_rsp)
    );

    always_comb begin
        cmp_req.valid         = r_rd_valid_bit;
        cmp_req.entry_content = r_rd_content;
        cmp_req.entry_host    = r_rd_host;
        cmp_req.key_content   = r_cid;
        cmp_req.key_host      = r_hid;
        cmp_req.use_host      = !scan_route;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_route_life_cfg <= ROUTE_LIFE_RST;
            r_pend_life_cfg  <= PEND_LIFE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_ROUTE_LIFE) begin
                r_route_life_cfg <= i_cfg_data;
            end else begin
                r_pend_life_cfg <= i_cfg_data;
            end
        end
    end

    // registered memory reads, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (scan_route) begin
            r_rd_content <= m_rcontent[r_idx[RW-1:0]];
            r_rd_rdata   <= m_rdata[r_idx[RW-1:0]];
        end else begin
            r_rd_content <= m_pcontent[r_idx[PW-1:0]];
            r_rd_host    <= m_phost[r_idx[PW-1:0]];
            r_rd_pdata   <= m_pdata[r_idx[PW-1:0]];
        end
        r_cmp_rdata <= r_rd_rdata;
        r_cmp_pdata <= r_rd_pdata;
    end

    // aged life values
    logic [7:0] rlife_dec, plife_dec;
    assign rlife_dec = (r_cmp_rdata[7:0] <= 8'd1) ? 8'd0 : r_cmp_rdata[7:0] - 8'd1;
    assign plife_dec = (r_cmp_pdata[7:0] <= 8'd1) ? 8'd0 : r_cmp_pdata[7:0] - 8'd1;

    // memory writes
    always_ff @(posedge i_clk) begin
        if (r_state == S_RWRITE && !r_found && r_free_found) begin
            m_rcontent[r_free_idx[RW-1:0]] <= r_cid;
            m_rdata[r_free_idx[RW-1:0]]    <= {r_port, r_hops, r_route_life_cfg};
        end else if (r_state == S_RWRITE && r_found) begin
            if (r_found_rdata[15:8] > r_hops) begin
                m_rdata[r_found_idx[RW-1:0]] <= {r_port, r_hops, r_route_life_cfg};
            end else if (r_found_rdata[15:8] == r_hops && r_found_rdata[17:16] == r_port) begin
                m_rdata[r_found_idx[RW-1:0]] <= {r_found_rdata[17:8], r_route_life_cfg};
            end
        end else if (r_state == S_RTICK && r_cmp_v && !cmp_rsp.free) begin
            m_rdata[r_cmp_idx[RW-1:0]] <= {r_cmp_rdata[17:8], rlife_dec};
        end
        if (r_state == S_PWRITE && !r_found && r_free_found) begin
            m_pcontent[r_free_idx[PW-1:0]] <= r_cid;
            m_phost[r_free_idx[PW-1:0]]    <= r_hid;
            m_pdata[r_free_idx[PW-1:0]]    <= {r_port, r_pend_life_cfg};
        end else if (r_state == S_PTICK && r_cmp_v && !cmp_rsp.free) begin
            m_pdata[r_cmp_idx[PW-1:0]] <= {r_cmp_pdata[9:8], plife_dec};
        end
    end

    // in tick scans the key is ignored: only the free flag is used
    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rvalid <= '0;
            r_pvalid <= '0;
            r_idx    <= '0;
            r_rd_v   <= 1'b0;
            r_cmp_v  <= 1'b0;
            r_found  <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            // pipeline of the scan
            r_rd_v   <= 1'b0;
            r_cmp_v  <= r_rd_v;
            r_rd_idx <= r_idx;
            r_cmp_idx <= r_rd_idx;
            if ((r_state == S_PSCAN || r_state == S_RSCAN || r_state == S_RTICK
                 || r_state == S_PTICK) && r_idx != scan_len) begin
                r_rd_v <= 1'b1;
                r_idx  <= r_idx + 1'b1;
                r_rd_valid_bit <= scan_route ? r_rvalid[r_idx[RW-1:0]]
                                             : r_pvalid[r_idx[PW-1:0]];
            end
            // collect first hit and first free slot
            if (r_cmp_v && (r_state == S_PSCAN || r_state == S_RSCAN)) begin
                if (cmp_rsp.hit && !r_found) begin
                    r_found       <= 1'b1;
                    r_found_idx   <= r_cmp_idx;
                    r_found_rdata <= r_cmp_rdata;
                    r_found_pdata <= r_cmp_pdata;
                end
                if (cmp_rsp.free && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_cmp_idx;
                end
            end
            // aging
            if (r_cmp_v && r_state == S_RTICK && !cmp_rsp.free
                && r_cmp_rdata[7:0] <= 8'd1) begin
                r_rvalid[r_cmp_idx[RW-1:0]] <= 1'b0;
            end
            if (r_cmp_v && r_state == S_PTICK && !cmp_rsp.free
                && r_cmp_pdata[7:0] <= 8'd1) begin
                r_pvalid[r_cmp_idx[PW-1:0]] <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op   <= s_axis_tdata[1:0];
                        r_port <= s_axis_tdata[3:2];
                        r_cid  <= s_axis_tdata[35:4];
                        r_hid  <= s_axis_tdata[67:36];
                        r_hops <= s_axis_tdata[75:68];
                        r_idx  <= '0;
                        r_found <= 1'b0;
                        r_free_found <= 1'b0;
                        r_mask   <= 4'd0;
                        r_ohops  <= 8'd0;
                        r_status <= ST_FORWARDED;
                        r_pfull  <= 1'b0;
                        case (s_axis_tdata[1:0])
                            OP_UPDATE: r_state <= S_RSCAN;
                            OP_TICK:   r_state <= S_RTICK;
                            default:   r_state <= S_PSCAN;
                        endcase
                    end
                end
                S_PSCAN: begin
                    if (scan_done) begin
                        if (r_op == OP_RESPONSE) begin
                            if (r_found) begin
                                r_mask <= 4'd1 << r_found_pdata[9:8];
                            end else begin
                                r_status <= ST_NO_MATCH;
                            end
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_PWRITE;
                        end
                    end
                end
                S_PWRITE: begin
                    if (!r_found) begin
                        if (r_free_found) begin
                            r_pvalid[r_free_idx[PW-1:0]] <= 1'b1;
                        end else begin
                            r_pfull <= 1'b1;
                        end
                    end
                    r_found <= 1'b0;
                    r_free_found <= 1'b0;
                    r_idx   <= '0;
                    r_state <= S_RSCAN;
                end
                S_RSCAN: begin
                    if (scan_done) begin
                        if (r_op == OP_UPDATE) begin
                            r_state <= S_RWRITE;
                        end else begin
                            if (r_found) begin
                                r_mask <= 4'd1 << r_found_rdata[17:16];
                            end else begin
                                r_status <= ST_NO_MATCH;
                            end
                            if (r_pfull) begin
                                r_status <= ST_FULL;
                            end
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RWRITE: begin
                    if (!r_found) begin
                        if (r_free_found) begin
                            r_rvalid[r_free_idx[RW-1:0]] <= 1'b1;
                        end else begin
                            r_status <= ST_FULL;
                        end
                    end
                    r_mask  <= 4'hF & ~(4'd1 << r_port);
                    r_ohops <= (r_hops == 8'hFF) ? 8'hFF : r_hops + 8'd1;
                    r_state <= S_OUT;
                end
                S_RTICK: begin
                    if (scan_done) begin
                        r_idx   <= '0;
                        r_state <= S_PTICK;
                    end
                end
                S_PTICK: begin
                    if (scan_done) begin
                        r_status <= ST_TICK;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // no new transaction while a result waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("accepting while result pending");

    // a tick always reports tick done
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_op == OP_TICK) |-> (r_status == ST_TICK && r_mask == 4'd0))
        else $error("tick result wrong");

    // an update never floods back to its arrival port
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_op == OP_UPDATE) |-> (r_mask[r_port] == 1'b0))
        else $error("update flooded to arrival port");

endmodule

// ----- hw/rtl/crrpt_match.sv -----
module crrpt_match
    import crrpt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmp_req i_req,
    output t_cmp_rsp o_rsp
);

    t_cmp_rsp r_rsp;
    t_cmp_rsp n_rsp;

    // shared key comparator, one entry per cycle, registered result
    always_comb begin
        n_rsp.free = !i_req.valid;
        n_rsp.hit  = i_req.valid && (i_req.entry_content == i_req.key_content)
                     && (!i_req.use_host || (i_req.entry_host == i_req.key_host));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp <= '0;
        end else begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule
